[hw/rtl/dto_pkg.sv]
// shared constants and types for the dependency topological order block
`default_nettype none
package dto_pkg;
   localparam int MAX_QUBITS = 64;
   localparam int QW = $clog2(MAX_QUBITS);
   localparam int NW = QW + 1;

   localparam logic KIND_EDGE   = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   typedef logic [MAX_QUBITS-1:0] row_type;

   // lowest set bit of a mask, zero when empty
   function automatic logic [QW-1:0] lowest_bit(input row_type m);
      logic [QW-1:0] r;
      r = '0;
      for (int i = MAX_QUBITS - 1; i >= 0; i--) begin
         if (m[i]) begin
            r = QW'(i);
         end
      end
      return r;
   endfunction
endpackage
`default_nettype wire

[hw/rtl/dto_edge_mem.sv]
// edge matrix memory: one row per target, bit per control, with per-row valid bits
`default_nettype none
module dto_edge_mem
   import dto_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          clr,
   input  wire logic          wr_en,
   input  wire logic [QW-1:0] wr_row,
   input  wire row_type       wr_data,
   input  wire logic [QW-1:0] rd_row,
   output row_type            rd_data
);
   row_type mem [MAX_QUBITS];
   row_type vld_ff;
   logic    rd_vld_ff;
   row_type rd_raw_ff;

   // row valid bits, cleared at once
   always_ff @(posedge clock) begin
      if (reset || clr) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_row] <= 1'b1;
      end
   end

   // storage array with registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_row] <= wr_data;
      end
      rd_raw_ff <= mem[rd_row];
      rd_vld_ff <= vld_ff[rd_row] && !(reset || clr);
   end

   assign rd_data = rd_vld_ff ? rd_raw_ff : '0;
endmodule
`default_nettype wire

[hw/rtl/dependency_topological_order.sv]
// top level: edge loading and kahn sort sequencer
//  channel | ports                                          | handshake
//  request | req_kind, req_control_qubit, req_target_qubit | start / busy
//  result  | rsp_qubit_index, rsp_order_position,           | rsp_valid strobe
//          | rsp_keep_layout, rsp_last_result               |
//  config  | csr_data                                       | csr_valid / csr_ready
// an edge request reads a row then writes it back; the edge memory has one read port.
// a finish counts pending controls row by row, checks, then sorts by a pick and an
// apply per placed qubit, then streams a result per qubit or one keep-layout result.
// a clear state empties pending counts, ready set and edge rows after each finish;
// streamed results trail the sequencer by two register stages.
// reset is synchronous; results cannot be stalled by the receiver.
`default_nettype none
module dependency_topological_order
   import dto_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire logic          req_kind,
   input  wire logic [QW-1:0] req_control_qubit,
   input  wire logic [QW-1:0] req_target_qubit,
   output logic               rsp_valid,
   output logic [QW-1:0]      rsp_qubit_index,
   output logic [QW-1:0]      rsp_order_position,
   output logic               rsp_keep_layout,
   output logic               rsp_last_result,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [NW-1:0] csr_data
);
   localparam logic [3:0] S_IDLE = 4'd0, S_EREAD = 4'd1, S_EWRITE = 4'd2,
      S_CREAD = 4'd3, S_CACC = 4'd4, S_CHECK = 4'd5, S_PICK = 4'd6,
      S_PAPPLY = 4'd7, S_EMIT = 4'd8, S_KEEP = 4'd9, S_CLEAR = 4'd10;

   logic [3:0]    st_ff, st_in;
   logic [NW-1:0] nq_ff;
   logic [NW-1:0] n_ff, n_in;
   logic [QW-1:0] ctl_ff, ctl_in, tgt_ff, tgt_in;
   logic [NW-1:0] idx_ff, idx_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   row_type       ready_ff, ready_in, valid_ff, valid_in;
   logic [NW-1:0] pend_ff [MAX_QUBITS];
   logic [NW-1:0] pend_in [MAX_QUBITS];
   logic [QW-1:0] pos_mem [MAX_QUBITS];
   logic [QW-1:0] pos_rd_ff;
   logic          pos_we;
   logic [QW-1:0] pos_wa, pos_ra;
   logic          em_clr, em_we;
   logic [QW-1:0] em_wr, em_rd;
   row_type       em_wd, em_q, row_v;
   logic          emit_ff, emit_in, last_ff, last_in;
   logic [QW-1:0] eq_ff, eq_in;

   dto_edge_mem u_mem (
      .clock(clock), .reset(reset), .clr(em_clr), .wr_en(em_we), .wr_row(em_wr),
      .wr_data(em_wd), .rd_row(em_rd), .rd_data(em_q)
   );

   assign busy = (st_ff != S_IDLE);
   assign csr_ready = (st_ff == S_IDLE);
   assign row_v = em_q & valid_ff;

   // position store
   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[pos_wa] <= cnt_ff[QW-1:0];
      end
      pos_rd_ff <= pos_mem[pos_ra];
   end

   // sequencer
   always_comb begin
      logic [NW-1:0] nc;
      logic          waiting;
      st_in = st_ff; n_in = n_ff; ctl_in = ctl_ff; tgt_in = tgt_ff;
      idx_in = idx_ff; cnt_in = cnt_ff; ready_in = ready_ff; valid_in = valid_ff;
      pend_in = pend_ff;
      em_clr = 1'b0; em_we = 1'b0; em_wr = tgt_ff; em_wd = em_q | (row_type'(1) << ctl_ff);
      em_rd = tgt_ff; pos_we = 1'b0; pos_wa = idx_ff[QW-1:0]; pos_ra = '0;
      emit_in = 1'b0; last_in = 1'b0; eq_in = eq_ff;
      nc = (nq_ff > NW'(MAX_QUBITS)) ? NW'(MAX_QUBITS) : nq_ff;
      waiting = 1'b0;
      unique case (st_ff)
         S_IDLE: begin
            em_rd = req_target_qubit;
            if (start) begin
               if (req_kind == KIND_EDGE) begin
                  ctl_in = req_control_qubit; tgt_in = req_target_qubit;
                  st_in = S_EREAD;
               end else begin
                  n_in = nc;
                  valid_in = (nc >= NW'(MAX_QUBITS)) ? '1 : ((row_type'(1) << nc) - 1'b1);
                  idx_in = '0; cnt_in = '0;
                  st_in = (nc < NW'(2)) ? S_KEEP : S_CREAD;
               end
            end
         end
         S_EREAD: st_in = S_EWRITE;
         S_EWRITE: begin
            em_we = 1'b1;
            st_in = S_IDLE;
         end
         // pending count build: read row t, add its controls
         S_CREAD: begin
            em_rd = idx_ff[QW-1:0];
            st_in = S_CACC;
         end
         S_CACC: begin
            for (int c = 0; c < MAX_QUBITS; c++) begin
               if (row_v[c]) pend_in[c] = pend_ff[c] + 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            st_in = (idx_ff + 1'b1 == n_ff) ? S_CHECK : S_CREAD;
         end
         S_CHECK: begin
            for (int q = 0; q < MAX_QUBITS; q++) begin
               if (valid_ff[q]) begin
                  if (pend_ff[q] == '0) ready_in[q] = 1'b1;
                  else waiting = 1'b1;
               end
            end
            st_in = waiting ? S_PICK : S_KEEP;
         end
         // take lowest ready qubit and read its row
         S_PICK: begin
            if (ready_ff == '0) begin
               idx_in = '0;
               st_in = (cnt_ff == n_ff) ? S_EMIT : S_KEEP;
               pos_ra = '0;
            end else begin
               tgt_in = lowest_bit(ready_ff);
               em_rd = lowest_bit(ready_ff);
               ready_in[lowest_bit(ready_ff)] = 1'b0;
               idx_in = NW'(lowest_bit(ready_ff));
               pos_we = 1'b1; pos_wa = lowest_bit(ready_ff);
               cnt_in = cnt_ff + 1'b1;
               st_in = S_PAPPLY;
            end
         end
         S_PAPPLY: begin
            for (int c = 0; c < MAX_QUBITS; c++) begin
               if (row_v[c] && pend_ff[c] != '0) begin
                  pend_in[c] = pend_ff[c] - 1'b1;
                  if (pend_ff[c] == NW'(1)) ready_in[c] = 1'b1;
               end
            end
            st_in = S_PICK;
         end
         // stream positions, read lands with the emit stage
         S_EMIT: begin
            pos_ra = idx_ff[QW-1:0];
            emit_in = 1'b1; eq_in = idx_ff[QW-1:0];
            last_in = (idx_ff + 1'b1 == n_ff);
            idx_in = idx_ff + 1'b1;
            if (idx_ff + 1'b1 == n_ff) begin
               idx_in = '0; st_in = S_CLEAR;
            end
         end
         S_KEEP: begin
            idx_in = '0; st_in = S_CLEAR;
         end
         S_CLEAR: begin
            em_clr = 1'b1;
            for (int q = 0; q < MAX_QUBITS; q++) pend_in[q] = '0;
            ready_in = '0;
            st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   // result register
   logic          rv_ff, rk_ff, rl_ff;
   logic [QW-1:0] rq_ff;
   logic          ek_ff;
   logic [QW-1:0] pos_rd_hold;
   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= emit_ff || (st_ff == S_KEEP);
      end
      rk_ff <= (st_ff == S_KEEP);
      rl_ff <= (st_ff == S_KEEP) || last_ff;
      rq_ff <= (st_ff == S_KEEP) ? '0 : eq_ff;
   end

   // position aligned to emit stage
   always_ff @(posedge clock) begin
      ek_ff <= emit_ff;
      pos_rd_hold <= pos_rd_ff;
   end

   assign rsp_valid = rv_ff;
   assign rsp_qubit_index = rq_ff;
   assign rsp_order_position = rk_ff ? '0 : (ek_ff ? pos_rd_hold : '0);
   assign rsp_keep_layout = rk_ff;
   assign rsp_last_result = rl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; nq_ff <= '0; emit_ff <= 1'b0;
         ready_ff <= '0; cnt_ff <= '0; idx_ff <= '0;
         for (int q = 0; q < MAX_QUBITS; q++) pend_ff[q] <= '0;
      end else begin
         st_ff <= st_in; emit_ff <= emit_in;
         ready_ff <= ready_in; cnt_ff <= cnt_in; idx_ff <= idx_in;
         pend_ff <= pend_in;
         if (csr_valid && csr_ready) nq_ff <= csr_data;
      end
      n_ff <= n_in; ctl_ff <= ctl_in; tgt_ff <= tgt_in; valid_ff <= valid_in;
      last_ff <= last_in; eq_ff <= eq_in;
   end
endmodule
`default_nettype wire

[hw/rtl/dto_checker.sv]
// port level checks for the topological order block
`default_nettype none
module dto_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic busy,
   input wire logic start,
   input wire logic rsp_valid,
   input wire logic rsp_keep_layout,
   input wire logic rsp_last_result,
   input wire logic csr_ready
);
   a_keep_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_keep_layout |-> rsp_last_result) else $error("keep without last");
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> !busy) else $error("config taken while busy");
   a_last_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_result |=> !rsp_valid) else $error("result after last");
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("request taken without going busy");
endmodule
bind dependency_topological_order dto_checker u_chk (.*);
`default_nettype wire
